@@ hdl/cesd_pkg.sv @@
// ---------------------------------------------------------------------------
// cesd_pkg: shared types, constants and functions
// Types and helper functions for the escape sequence decoder.
// ---------------------------------------------------------------------------
package cesd_pkg;

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_X    = 8'h78;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] OCT_TOP   = 8'h37;
	localparam logic [7:0] DEC_TOP   = 8'h39;
	localparam logic [1:0] HEX_MAX   = 2'd2;
	localparam logic [1:0] NUM_MAX   = 2'd3;
	localparam int         QUEUE_DEPTH = 2;
	localparam int         QPTR_W    = $clog2(QUEUE_DEPTH);
	localparam int         QCNT_W    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ESC,
		PH_HEX,
		PH_NUM
	} phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       out_last;
	} result_t;

	// One queue word: the results that one input byte causes.
	typedef struct packed {
		logic    two;
		result_t res0;
		result_t res1;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// Returns {valid, value} for an ASCII hex digit of either case.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic [7:0] named_code(input logic [7:0] b);
		logic [7:0] r;
		unique case (b)
			8'h65: r = 8'h1B;
			8'h61: r = 8'h07;
			8'h62: r = 8'h08;
			8'h66: r = 8'h0C;
			8'h6E: r = 8'h0A;
			8'h72: r = 8'h0D;
			8'h74: r = 8'h09;
			8'h76: r = 8'h0B;
			default: r = b;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/cesd_front.sv @@
// ---------------------------------------------------------------------------
// cesd_front: byte classifier and escape state machine
// Accepts raw bytes, tracks the escape state and pushes the results that
// each byte causes as one queue word.
// ---------------------------------------------------------------------------
module cesd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_data,
	input  logic               in_valid,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	input  logic               q_full,
	output logic               in_stall,
	output logic               push,
	output cesd_pkg::entry_t   entry
);
	import cesd_pkg::*;

	phase_t     phase_q, phase_nxt;
	logic [1:0] cnt_q, cnt_nxt;
	logic [7:0] acc_q, acc_nxt;
	logic       octal_mode_q;

	logic       accept;
	logic [4:0] hex_d;
	logic       num_ok;
	logic [2:0] num_d;
	logic [7:0] acc_hex, acc_num;
	logic [1:0] cnt_inc;
	result_t    plain_res;
	logic       plain_emits;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	assign hex_d   = hex_digit(in_byte);
	assign num_ok  = (in_byte >= CHAR_ZERO) && (in_byte <= (octal_mode_q ? OCT_TOP : DEC_TOP));
	assign num_d   = in_byte[2:0];
	assign cnt_inc = cnt_q + 2'd1;
	assign acc_hex = {acc_q[3:0], 4'd0} + {4'd0, hex_d[3:0]};
	// Times ten is eight plus two; the bit-3 digit only exists in decimal mode.
	assign acc_num = octal_mode_q ? ({acc_q[4:0], 3'd0} + {5'd0, num_d})
	                              : ({acc_q[4:0], 3'd0} + {acc_q[6:0], 1'b0}
	                                 + {4'd0, in_byte[3:0]});

	// Ordinary handling of a byte; a backslash opens an escape unless it ends the string.
	always_comb begin
		plain_emits = (in_byte != BACKSLASH) || in_last;
		if (in_byte == BACKSLASH) begin
			plain_res = '{out_byte: 8'd0, has_byte: 1'b0, out_last: 1'b1};
		end else begin
			plain_res = '{out_byte: in_byte, has_byte: 1'b1, out_last: in_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octal_mode_q <= 1'b0;
		end else if (cfg_we) begin
			octal_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= 2'd0;
			acc_q   <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			cnt_q   <= cnt_nxt;
			acc_q   <= acc_nxt;
		end
	end

	// Next state.
	always_comb begin
		phase_nxt = PH_IDLE;
		cnt_nxt   = 2'd0;
		acc_nxt   = 8'd0;
		unique case (phase_q)
			PH_IDLE: begin
				if (!plain_emits) phase_nxt = PH_ESC;
			end
			PH_ESC: begin
				if (in_last) begin
					phase_nxt = PH_IDLE;
				end else if (in_byte == CHAR_X) begin
					phase_nxt = PH_HEX;
				end else if (num_ok) begin
					phase_nxt = PH_NUM;
					cnt_nxt   = 2'd1;
					acc_nxt   = {4'd0, in_byte[3:0]};
				end
			end
			PH_HEX: begin
				if (hex_d[4]) begin
					if (!(cnt_inc >= HEX_MAX || in_last)) begin
						phase_nxt = PH_HEX;
						cnt_nxt   = cnt_inc;
						acc_nxt   = acc_hex;
					end
				end else if (!plain_emits) begin
					phase_nxt = PH_ESC;
				end
			end
			PH_NUM: begin
				if (num_ok) begin
					if (!(cnt_inc >= NUM_MAX || in_last)) begin
						phase_nxt = PH_NUM;
						cnt_nxt   = cnt_inc;
						acc_nxt   = acc_num;
					end
				end else if (!plain_emits) begin
					phase_nxt = PH_ESC;
				end
			end
			default: phase_nxt = PH_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		logic emit;
		emit       = 1'b0;
		entry.two  = 1'b0;
		entry.res0 = '{out_byte: 8'd0, has_byte: 1'b1, out_last: in_last};
		entry.res1 = plain_res;
		unique case (phase_q)
			PH_IDLE: begin
				emit       = plain_emits;
				entry.res0 = plain_res;
			end
			PH_ESC: begin
				if (in_byte == CHAR_X) begin
					emit = in_last;
				end else if (num_ok) begin
					emit                = in_last;
					entry.res0.out_byte = {4'd0, in_byte[3:0]};
				end else begin
					emit                = 1'b1;
					entry.res0.out_byte = named_code(in_byte);
				end
			end
			PH_HEX, PH_NUM: begin
				if ((phase_q == PH_HEX) ? hex_d[4] : num_ok) begin
					emit = in_last ||
					       ((phase_q == PH_HEX) ? (cnt_inc >= HEX_MAX) : (cnt_inc >= NUM_MAX));
					entry.res0.out_byte = (phase_q == PH_HEX) ? acc_hex : acc_num;
				end else begin
					// The run closes on a non-digit, which is then handled afresh.
					emit                = 1'b1;
					entry.two           = plain_emits;
					entry.res0.out_byte = acc_q;
					entry.res0.out_last = 1'b0;
				end
			end
			default: emit = 1'b0;
		endcase
		push = accept && emit;
	end

	property p_last_returns_idle;
		@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |=> (phase_q == PH_IDLE && cnt_q == 2'd0);
	endproperty
	a_last_returns_idle: assert property (p_last_returns_idle)
		else $error("phase not idle after a last byte");

	property p_last_pushes;
		@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |-> (push && (entry.two ? entry.res1.out_last : entry.res0.out_last));
	endproperty
	a_last_pushes: assert property (p_last_pushes)
		else $error("last byte did not produce a final result");

	property p_count_range;
		@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEX) |-> (cnt_q < HEX_MAX);
	endproperty
	a_count_range: assert property (p_count_range)
		else $error("hex run holds too many digits");

endmodule

@@ hdl/cesd_queue.sv @@
// ---------------------------------------------------------------------------
// cesd_queue: short queue between the front and back parts
// Two-word FIFO of decoded result words.
// ---------------------------------------------------------------------------
module cesd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cesd_pkg::entry_t     wr_entry,
	input  logic                 pop,
	output cesd_pkg::entry_t     head,
	output cesd_pkg::q_status_t  status
);
	import cesd_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign status.empty = (cnt_q == QCNT_W'(0));
	assign status.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n)
		push |-> !status.full;
	endproperty
	a_no_overflow: assert property (p_no_overflow)
		else $error("word written into a full queue");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty;
	endproperty
	a_no_underflow: assert property (p_no_underflow)
		else $error("word read from an empty queue");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound)
		else $error("queue fill count out of range");

endmodule

@@ hdl/cesd_back.sv @@
// ---------------------------------------------------------------------------
// cesd_back: result sequencer and output register
// Takes queue words and presents their results one per cycle unless stalled.
// ---------------------------------------------------------------------------
module cesd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cesd_pkg::entry_t     head,
	input  cesd_pkg::q_status_t  status,
	output logic                 pop,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [7:0]           out_byte,
	output logic                 has_byte,
	output logic                 out_last
);
	import cesd_pkg::*;

	logic    out_valid_q;
	result_t out_q;
	logic    second_q;
	logic    load;

	assign load = !out_valid_q || !out_stall;
	// A two-result word stays at the head until its second result is loaded.
	assign pop  = load && !status.empty && (second_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= !status.empty;
			if (!status.empty) begin
				second_q <= !second_q && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !status.empty) begin
			out_q <= second_q ? head.res1 : head.res0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_q.out_byte;
	assign has_byte  = out_q.has_byte;
	assign out_last  = out_q.out_last;

	property p_second_has_word;
		@(posedge clk) disable iff (!arst_n)
		second_q |-> (!status.empty && head.two && out_valid_q);
	endproperty
	a_second_has_word: assert property (p_second_has_word)
		else $error("second result pending without its word");

	property p_second_follows;
		@(posedge clk) disable iff (!arst_n)
		(load && !status.empty && !second_q && head.two) |=> second_q;
	endproperty
	a_second_follows: assert property (p_second_follows)
		else $error("second result of a word was skipped");

	property p_pop_clears_second;
		@(posedge clk) disable iff (!arst_n)
		pop |=> !second_q;
	endproperty
	a_pop_clears_second: assert property (p_pop_clears_second)
		else $error("sequencer did not return to the first result");

endmodule

@@ hdl/c_escape_sequence_decoder.sv @@
// ---------------------------------------------------------------------------
// c_escape_sequence_decoder: C-style backslash escape decoder
// Decodes named, hex and decimal or octal escapes in a byte stream.
// ---------------------------------------------------------------------------
// Input channel: in_valid, in_stall, in_byte, in_last. A word is taken at a
// clock edge with in_valid high and in_stall low; in_last marks the end of a
// string. Output channel: out_valid, out_stall, out_byte, has_byte, out_last,
// one decoded result per word; has_byte low marks an end-only result.
// cfg_we writes cfg_data into the octal mode bit; write it only while idle.
// A byte yields no, one or two results. The front part takes one byte per
// cycle while in_stall is low; the back part delivers one result per cycle
// while out_stall is low, so a byte that closes a hex or numeric run and
// itself yields a result puts two results on the output.
// A result is written into the queue at the accepting edge, and the output
// register loads it from the queue head when the output is not stalled.
// The queue fill sets in_stall: while out_stall is high the output holds
// and the queue absorbs up to two more words before in_stall rises.
// Reset clears the escape state, the queue and the octal mode bit.
// ---------------------------------------------------------------------------
module c_escape_sequence_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       out_last
);
	import cesd_pkg::*;

	logic      push, pop;
	entry_t    wr_entry, head;
	q_status_t status;

	cesd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (status.full),
		.in_stall (in_stall),
		.push     (push),
		.entry    (wr_entry)
	);

	cesd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.status   (status)
	);

	cesd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (status),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.out_last  (out_last)
	);

endmodule
